// ===== src/iphg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iphg_pkg
// Shared types, constants and helpers of the IPv4 header generator.
// ----------------------------------------------------------------------------
package iphg_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TTL     = 2'd0;
  localparam logic [1:0] REG_MAX_LEN = 2'd1;

  // reset values of the configuration registers
  localparam logic [7:0]  TTL_RST     = 8'd64;
  localparam logic [15:0] MAX_LEN_RST = 16'd65515;

  // fixed header contents
  localparam logic [7:0]  VERSION_IHL = 8'h45;
  localparam logic [15:0] HDR_BYTES   = 16'd20;
  localparam logic [4:0]  HDR_LAST    = 5'd19;

  // queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // one classified request, ready for the byte emitter
  typedef struct packed {
    logic        rej;
    logic [15:0] total;
    logic [15:0] ident;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] csum;
  } entry_t;

  // end-around carry fold of a 19-bit word sum, then complement
  function automatic logic [15:0] ones_fold(input logic [18:0] s);
    logic [16:0] a;
    logic [15:0] f;
    a = {1'b0, s[15:0]} + {14'b0, s[18:16]};
    f = a[15:0] + {15'b0, a[16]};
    return ~f;
  endfunction

  // header byte at a wire position
  function automatic logic [7:0] hdr_byte(input entry_t e, input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = VERSION_IHL;
      5'd2:    b = e.total[15:8];
      5'd3:    b = e.total[7:0];
      5'd4:    b = e.ident[15:8];
      5'd5:    b = e.ident[7:0];
      5'd8:    b = e.ttl;
      5'd9:    b = e.proto;
      5'd10:   b = e.csum[15:8];
      5'd11:   b = e.csum[7:0];
      5'd12:   b = e.src[31:24];
      5'd13:   b = e.src[23:16];
      5'd14:   b = e.src[15:8];
      5'd15:   b = e.src[7:0];
      5'd16:   b = e.dst[31:24];
      5'd17:   b = e.dst[23:16];
      5'd18:   b = e.dst[15:8];
      5'd19:   b = e.dst[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/iphg_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iphg_front
// Accepts requests, holds configuration, checks the length, assigns the
// identification and computes the header checksum over two stages.
// ----------------------------------------------------------------------------
module iphg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          in_protocol_number,
  input  logic [31:0]         in_source_address,
  input  logic [31:0]         in_dest_address,
  input  logic [15:0]         in_payload_length,
  output logic                q_wr,
  input  logic                q_full,
  output iphg_pkg::entry_t    q_wdata
);
  import iphg_pkg::*;

  logic [7:0]  ttl_r;
  logic [15:0] max_len_r;
  logic [15:0] ident_r;

  logic        v1_r;
  logic        s1_rej_r;
  logic [15:0] s1_total_r;
  logic [15:0] s1_ident_r;
  logic [7:0]  s1_ttl_r;
  logic [7:0]  s1_proto_r;
  logic [31:0] s1_src_r;
  logic [31:0] s1_dst_r;
  logic [16:0] s1_sa_r;
  logic [16:0] s1_sd_r;

  logic        v2_r;
  entry_t      s2_ent_r;
  logic [18:0] s2_sum_r;
  logic [18:0] sum_nxt;

  logic acc, rej_in, s1_free, s2_free;

  // stage handshakes
  assign s2_free = !v2_r || !q_full;
  assign s1_free = !v1_r || s2_free;
  assign full    = !s1_free;
  assign acc     = push && s1_free;
  assign rej_in  = in_payload_length > max_len_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r     <= TTL_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TTL:     ttl_r     <= cfg_wdata[7:0];
        REG_MAX_LEN: max_len_r <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // identification counter, advances on each good transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= 16'd1;
    end else if (acc && !rej_in) begin
      ident_r <= ident_r + 16'd1;
    end
  end

  // stage 1: capture, length check, address word sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (s1_free) begin
      v1_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rej_r   <= rej_in;
      s1_total_r <= in_payload_length + HDR_BYTES;
      s1_ident_r <= ident_r;
      s1_ttl_r   <= ttl_r;
      s1_proto_r <= in_protocol_number;
      s1_src_r   <= in_source_address;
      s1_dst_r   <= in_dest_address;
      s1_sa_r    <= {1'b0, in_source_address[31:16]} + {1'b0, in_source_address[15:0]};
      s1_sd_r    <= {1'b0, in_dest_address[31:16]} + {1'b0, in_dest_address[15:0]};
    end
  end

  // stage 2: full word sum of the header
  assign sum_nxt = {2'b0, s1_sa_r} + {2'b0, s1_sd_r} + {3'b0, s1_total_r}
                 + {3'b0, s1_ident_r} + {3'b0, s1_ttl_r, s1_proto_r}
                 + {3'b0, VERSION_IHL, 8'h00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_free) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && v1_r) begin
      s2_ent_r.rej   <= s1_rej_r;
      s2_ent_r.total <= s1_total_r;
      s2_ent_r.ident <= s1_ident_r;
      s2_ent_r.ttl   <= s1_ttl_r;
      s2_ent_r.proto <= s1_proto_r;
      s2_ent_r.src   <= s1_src_r;
      s2_ent_r.dst   <= s1_dst_r;
      s2_ent_r.csum  <= 16'h0000;
      s2_sum_r       <= sum_nxt;
    end
  end

  // fold and hand to the queue
  always_comb begin
    q_wdata      = s2_ent_r;
    q_wdata.csum = ones_fold(s2_sum_r);
  end
  assign q_wr = v2_r && !q_full;

endmodule

// ===== src/iphg_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iphg_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module iphg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  iphg_pkg::entry_t    wdata,
  output logic                q_full,
  input  logic                rd,
  output logic                q_empty,
  output iphg_pkg::entry_t    rdata
);
  import iphg_pkg::*;

  entry_t             mem_r [QDEPTH];
  logic [QAW-1:0]     wptr_r;
  logic [QAW-1:0]     rptr_r;
  logic [QCW-1:0]     cnt_r;
  logic               do_wr, do_rd;

  assign q_full  = (cnt_r == QCW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem_r[rptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == QAW'(QDEPTH - 1)) ? '0 : wptr_r + QAW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == QAW'(QDEPTH - 1)) ? '0 : rptr_r + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

endmodule

// ===== src/iphg_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iphg_emit
// Takes queued requests and sends their header bytes (one zero byte if
// rejected) one per cycle, unless pop stalls, through an output register.
// ----------------------------------------------------------------------------
module iphg_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  iphg_pkg::entry_t    q_rdata,
  output logic                q_rd,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_header_byte,
  output logic                out_last_byte,
  output logic                out_rejected
);
  import iphg_pkg::*;

  entry_t      cur_r;
  logic        busy_r;
  logic [4:0]  cnt_r;
  logic        ov_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        rej_r;
  logic        pop_ok, step, last;

  assign pop_ok = pop && ov_r;
  assign step   = busy_r && (!ov_r || pop_ok);
  assign last   = cur_r.rej || (cnt_r == HDR_LAST);
  assign q_rd   = !q_empty && (!busy_r || (step && last));

  // current request and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (step) begin
        cnt_r <= last ? 5'd0 : cnt_r + 5'd1;
      end
      if (q_rd) begin
        busy_r <= 1'b1;
      end else if (step && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur_r <= q_rdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step) begin
      ov_r <= 1'b1;
    end else if (pop_ok) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      byte_r <= cur_r.rej ? 8'h00 : hdr_byte(cur_r, cnt_r);
      last_r <= last;
      rej_r  <= cur_r.rej;
    end
  end

  assign empty           = !ov_r;
  assign out_header_byte = byte_r;
  assign out_last_byte   = last_r;
  assign out_rejected    = rej_r;

  // checks
  a_rej_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && rej_r |-> last_r)
    else $error("rejected transaction not marked last");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= HDR_LAST)
    else $error("byte position out of range");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !last |=> cnt_r == $past(cnt_r) + 5'd1)
    else $error("byte position skipped");

  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == 5'd0)
    else $error("idle emitter left mid header");

endmodule

// ===== src/ipv4_header_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_header_generator
// Builds 20-byte IPv4 headers with identification and header checksum,
// sent one byte per result transaction in wire order.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   push / full        in_protocol_number, in_source_address,
//                               in_dest_address, in_payload_length
//  result    empty / pop        out_header_byte, out_last_byte, out_rejected
//  config    cfg_we             cfg_index, cfg_wdata
//
//  a header goes out one byte per result transaction, a rejected request as
//  a single byte, paced by the back-end byte emitter; an accepted request
//  passes stage 1, stage 2, the queue, cur_r and the output register.
//  requests are taken back to back into a two-stage checksum pipeline and
//  a two-entry queue, so full rises only when these are all occupied.
//  reset is synchronous; ttl resets to 64, max length to 65515, ident to 1.
// ----------------------------------------------------------------------------
module ipv4_header_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_protocol_number,
  input  logic [31:0] in_source_address,
  input  logic [31:0] in_dest_address,
  input  logic [15:0] in_payload_length,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_header_byte,
  output logic        out_last_byte,
  output logic        out_rejected
);
  import iphg_pkg::*;

  logic   q_wr, q_full, q_rd, q_empty;
  entry_t q_wdata, q_rdata;

  // request side
  iphg_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .push               (push),
    .full               (full),
    .in_protocol_number (in_protocol_number),
    .in_source_address  (in_source_address),
    .in_dest_address    (in_dest_address),
    .in_payload_length  (in_payload_length),
    .q_wr               (q_wr),
    .q_full             (q_full),
    .q_wdata            (q_wdata)
  );

  // decoupling queue
  iphg_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .q_empty (q_empty),
    .rdata   (q_rdata)
  );

  // byte emitter
  iphg_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rdata         (q_rdata),
    .q_rd            (q_rd),
    .empty           (empty),
    .pop             (pop),
    .out_header_byte (out_header_byte),
    .out_last_byte   (out_last_byte),
    .out_rejected    (out_rejected)
  );

endmodule
